>>> hw/rtl/urav_pkg.sv
package urav_pkg;

   // field widths
   localparam int TIMER_W = 20;
   localparam int CNT_W   = 4;
   localparam int TEMP_W  = 9;
   localparam int SPEED_W = 22;
   localparam int PROD_W  = 42;
   localparam int SUM_W   = 45;
   localparam int DIVR_W  = 25;
   localparam int DIST_W  = 21;
   localparam int OFF_W   = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // one result bit per divider step
   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // speed of sound in 1e-4 m/s: base plus slope per tenth of a degree
   localparam logic [SPEED_W-1:0] SPEED_BASE  = 22'd3313000;
   localparam logic [SPEED_W-1:0] SPEED_SLOPE = 22'd606;
   // two-way path and unit scaling folded into one divisor per sample
   localparam logic [DIVR_W-1:0]  DIV_SCALE   = 25'd2000000;

   localparam logic signed [DIST_W-1:0] DIST_MAX = 21'sh0FFFFF;

   // register reset values
   localparam logic [TIMER_W-1:0] TIMEOUT_RST = 20'd300000;
   localparam logic [CNT_W-1:0]   SAMPLES_RST = 4'd5;
   localparam logic [15:0]        SETTLE_RST  = 16'd2000;
   localparam logic [9:0]         TRIGGER_RST = 10'd10;
   localparam logic [15:0]        GAP_RST     = 16'd10000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET  = 3'd5;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETTLE,
      PH_TRIG,
      PH_WLOW,
      PH_WHIGH,
      PH_MEAS,
      PH_GAP
   } phase_type;

   typedef enum logic [2:0] {
      C_IN,
      C_STEP,
      C_ACC,
      C_DLOAD,
      C_DIV,
      C_OUT
   } ctl_state_type;

   typedef struct packed {
      logic load_in;
      logic step;
      logic acc;
      logic div_load;
      logic div_step;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_stat_type;

endpackage

>>> hw/rtl/urav_ctrl.sv
module urav_ctrl
   import urav_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctl_state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         C_IN: begin
            if (req_valid) state_in = C_STEP;
         end
         C_STEP:  state_in = C_ACC;
         C_ACC: begin
            state_in = stat.need_div ? C_DLOAD : C_OUT;
         end
         C_DLOAD: state_in = C_DIV;
         C_DIV: begin
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = C_OUT;
         end
         C_OUT: begin
            if (out_free) state_in = C_IN;
         end
         default: state_in = C_IN;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         C_IN: begin
            req_stall   = 1'b0;
            cmd.load_in = req_valid;
         end
         C_STEP:  cmd.step = 1'b1;
         C_ACC:   cmd.acc = 1'b1;
         C_DLOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
         end
         C_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
         end
         C_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IN;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/urav_dp.sv
module urav_dp
   import urav_pkg::*;
#(
   parameter int MAX_SAMPLES = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_stat_type                  stat,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   input  logic                         req_start_req,
   input  logic                         req_echo,
   input  logic [TEMP_W-1:0]            req_temperature_tenths_c,
   output logic                         rsp_trigger,
   output logic                         rsp_busy_res,
   output logic                         rsp_done_res,
   output logic                         rsp_failed,
   output logic signed [DIST_W-1:0]     rsp_distance_hundredths_cm,
   output logic [CNT_W-1:0]             rsp_valid_samples
);

   // registers
   logic [TIMER_W-1:0]       timeout_ff;
   logic [CNT_W-1:0]         samples_ff;
   logic [15:0]              settle_ff;
   logic [9:0]               trigger_ff;
   logic [15:0]              gap_ff;
   logic signed [OFF_W-1:0]  offset_ff;

   // latched input word
   logic                     start_ff, echo_ff;
   logic [TEMP_W-1:0]        temp_ff;

   // measurement state
   phase_type                phase_ff, phase_in;
   logic [TIMER_W-1:0]       timer_ff, timer_in;
   logic [CNT_W-1:0]         attempt_ff, attempt_in;
   logic [CNT_W-1:0]         good_ff, good_in;
   logic [SPEED_W-1:0]       speed_ff, speed_in;
   logic [SUM_W-1:0]         sum_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic                     trig_ff, trig_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     smp_ff, smp_in;
   logic                     clr_in;

   // divider
   logic [DIVR_W-1:0]        divr_ff;
   logic [DIVR_W-1:0]        rem_ff;
   logic [SUM_W-1:0]         quo_ff;
   logic [DIVR_W:0]          shifted, diff;

   logic [TIMER_W-1:0]       timer_inc;
   logic [CNT_W-1:0]         attempt_nx;
   logic [CNT_W:0]           eff_count;
   logic                     end_att, go_settle;
   logic signed [DIST_W+1:0] dwide;
   logic signed [DIST_W-1:0] dist_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RST;
         samples_ff <= SAMPLES_RST;
         settle_ff  <= SETTLE_RST;
         trigger_ff <= TRIGGER_RST;
         gap_ff     <= GAP_RST;
         offset_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMEOUT: timeout_ff <= csr_wdata;
            CSR_SAMPLES: samples_ff <= csr_wdata[CNT_W-1:0];
            CSR_SETTLE:  settle_ff  <= csr_wdata[15:0];
            CSR_TRIGGER: trigger_ff <= csr_wdata[9:0];
            CSR_GAP:     gap_ff     <= csr_wdata[15:0];
            CSR_OFFSET:  offset_ff  <= $signed(csr_wdata[OFF_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         start_ff <= req_start_req;
         echo_ff  <= req_echo;
         temp_ff  <= req_temperature_tenths_c;
      end
   end

   // zero acts as one, clipped at the build-time maximum
   always_comb begin
      eff_count = {1'b0, samples_ff};
      if (eff_count == '0) eff_count = (CNT_W+1)'(1);
      if (eff_count > (CNT_W+1)'(MAX_SAMPLES)) eff_count = (CNT_W+1)'(MAX_SAMPLES);
   end

   assign timer_inc  = timer_ff + TIMER_W'(1);
   assign attempt_nx = attempt_ff + CNT_W'(1);

   // next state for one tick
   always_comb begin
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      attempt_in = attempt_ff;
      good_in    = good_ff;
      speed_in   = speed_ff;
      trig_in    = 1'b0;
      busy_in    = (phase_ff != PH_IDLE);
      done_in    = 1'b0;
      smp_in     = 1'b0;
      clr_in     = 1'b0;
      end_att    = 1'b0;
      go_settle  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start_ff) begin
               busy_in    = 1'b1;
               speed_in   = SPEED_BASE + SPEED_W'(temp_ff) * SPEED_SLOPE;
               attempt_in = '0;
               good_in    = '0;
               clr_in     = 1'b1;
               go_settle  = 1'b1;
            end
         end
         PH_SETTLE: begin
            if (timer_inc >= {4'b0, settle_ff}) begin
               phase_in = PH_TRIG;
               timer_in = '0;
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_TRIG: begin
            trig_in = 1'b1;
            if (timer_inc >= {10'b0, trigger_ff}) begin
               phase_in = PH_WLOW;
               timer_in = '0;
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_WLOW: begin
            if (!echo_ff) begin
               phase_in = PH_WHIGH;
               timer_in = '0;
            end else if (timer_ff >= timeout_ff) begin
               end_att = 1'b1;
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_WHIGH: begin
            if (echo_ff) begin
               phase_in = PH_MEAS;
               timer_in = TIMER_W'(1);
            end else if (timer_ff >= timeout_ff) begin
               end_att = 1'b1;
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_MEAS: begin
            if (!echo_ff) begin
               smp_in   = 1'b1;
               good_in  = good_ff + CNT_W'(1);
               timer_in = '0;
               if (gap_ff == '0) end_att = 1'b1;
               else phase_in = PH_GAP;
            end else if (timer_ff >= timeout_ff) begin
               end_att = 1'b1;
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_GAP: begin
            timer_in = timer_inc;
            if (timer_inc >= {4'b0, gap_ff}) end_att = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
            timer_in = '0;
         end
      endcase
      if (end_att) begin
         attempt_in = attempt_nx;
         if ({1'b0, attempt_nx} >= eff_count) begin
            phase_in = PH_IDLE;
            timer_in = '0;
            done_in  = 1'b1;
         end else begin
            go_settle = 1'b1;
         end
      end
      if (go_settle) begin
         timer_in = '0;
         phase_in = (settle_ff == '0) ? PH_TRIG : PH_SETTLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         timer_ff   <= '0;
         attempt_ff <= '0;
         good_ff    <= '0;
         speed_ff   <= '0;
         trig_ff    <= 1'b0;
         busy_ff    <= 1'b0;
         done_ff    <= 1'b0;
         smp_ff     <= 1'b0;
      end else if (cmd.step) begin
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         attempt_ff <= attempt_in;
         good_ff    <= good_in;
         speed_ff   <= speed_in;
         trig_ff    <= trig_in;
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         smp_ff     <= smp_in;
      end
   end

   // echo width times speed, taken from the count before it is cleared
   always_ff @(posedge clock) begin
      if (cmd.step) prod_ff <= PROD_W'(speed_ff) * PROD_W'(timer_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (cmd.step && clr_in) begin
         sum_ff <= '0;
      end else if (cmd.acc && smp_ff) begin
         sum_ff <= sum_ff + SUM_W'(prod_ff);
      end
   end

   assign stat.need_div = done_ff && (good_ff != '0);

   // restoring divider, one quotient bit a cycle
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, divr_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         divr_ff <= DIVR_W'(good_ff) * DIV_SCALE;
         rem_ff  <= '0;
         quo_ff  <= sum_ff;
      end else if (cmd.div_step) begin
         if (!diff[DIVR_W]) begin
            rem_ff <= diff[DIVR_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DIVR_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   // offset never drives the result below the low limit, only the top needs clipping
   always_comb begin
      dwide = $signed({2'b00, quo_ff[DIST_W-1:0]})
            - $signed({{(DIST_W+2-OFF_W){offset_ff[OFF_W-1]}}, offset_ff});
      if (|quo_ff[SUM_W-1:DIST_W]) begin
         dist_c = DIST_MAX;
      end else if (dwide > $signed({2'b00, DIST_MAX})) begin
         dist_c = DIST_MAX;
      end else begin
         dist_c = dwide[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_trigger                <= trig_ff;
         rsp_busy_res               <= busy_ff;
         rsp_done_res               <= done_ff;
         rsp_failed                 <= done_ff && (good_ff == '0);
         rsp_distance_hundredths_cm <= stat.need_div ? dist_c : '0;
         rsp_valid_samples          <= good_ff;
      end
   end

endmodule

>>> hw/rtl/ultrasonic_range_averager.sv
// Ultrasonic range averager.
// Each req_ word is one microsecond tick of the sensor: start request, sampled
// echo level and temperature. Each tick gives exactly one rsp_ word: trigger
// pin level, busy, done, failed, averaged distance and count of good samples.
// A word is taken when valid is high and stall is low, on either channel.
// csr_ writes set the six timing and calibration registers; csr_ready is
// always high. Write them only while no measurement is running.
// A tick is accepted, stepped, accumulated and output, and no new tick is
// taken until the previous one is output. The tick that ends a measurement
// with at least one good sample also loads and runs a restoring divider,
// producing one quotient bit per cycle over the 45 bit sum, before output.
// The rsp_ side has an output register: while the receiver stalls, the next
// tick is taken and worked on, then held until the register frees.
// Reset (synchronous) returns the block to idle with registers at defaults
// and no response pending.
module ultrasonic_range_averager
   import urav_pkg::*;
#(
   parameter int MAX_SAMPLES = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_start_req,
   input  logic                      req_echo,
   input  logic [TEMP_W-1:0]         req_temperature_tenths_c,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_trigger,
   output logic                      rsp_busy_res,
   output logic                      rsp_done_res,
   output logic                      rsp_failed,
   output logic signed [DIST_W-1:0]  rsp_distance_hundredths_cm,
   output logic [CNT_W-1:0]          rsp_valid_samples,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   urav_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   urav_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock                      (clock),
      .reset                      (reset),
      .cmd                        (cmd),
      .stat                       (stat),
      .csr_we                     (csr_valid && csr_ready),
      .csr_index                  (csr_index),
      .csr_wdata                  (csr_wdata),
      .req_start_req              (req_start_req),
      .req_echo                   (req_echo),
      .req_temperature_tenths_c   (req_temperature_tenths_c),
      .rsp_trigger                (rsp_trigger),
      .rsp_busy_res               (rsp_busy_res),
      .rsp_done_res               (rsp_done_res),
      .rsp_failed                 (rsp_failed),
      .rsp_distance_hundredths_cm (rsp_distance_hundredths_cm),
      .rsp_valid_samples          (rsp_valid_samples)
   );

   // no new word while the divider runs
   a_div_blocks_input: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> req_stall)
      else $error("input taken during division");

   // a failed measurement carries no distance and no good samples
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |->
         rsp_done_res && rsp_distance_hundredths_cm == '0 && rsp_valid_samples == '0)
      else $error("failed result with distance or samples");

   // distance only reported on a done word
   a_dist_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_distance_hundredths_cm == '0 && !rsp_failed)
      else $error("distance outside done word");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

endmodule

>>> tb/range_averager_check.sv
`timescale 1ns / 1ps

module range_averager_check
   import urav_pkg::*;
#(
   parameter int MAX_SAMPLES = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     req_start_req,
   input  logic                     req_echo,
   input  logic [TEMP_W-1:0]        req_temperature_tenths_c,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_trigger,
   input  logic                     rsp_busy_res,
   input  logic                     rsp_done_res,
   input  logic                     rsp_failed,
   input  logic signed [DIST_W-1:0] rsp_distance_hundredths_cm,
   input  logic [CNT_W-1:0]         rsp_valid_samples,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output int                       error_count,
   output int                       words_owed,
   output int                       measurements,
   output int                       empty_measurements
);

   typedef struct packed {
      logic                     trigger;
      logic                     busy;
      logic                     done;
      logic                     failed;
      logic signed [DIST_W-1:0] distance;
      logic [CNT_W-1:0]         samples;
   } tick_word_type;

   localparam longint DIST_HI = longint'(DIST_MAX);
   localparam longint DIST_LO = -DIST_HI - 1;

   // register copies
   logic [TIMER_W-1:0]      timeout_reg;
   logic [CNT_W-1:0]        samples_reg;
   logic [15:0]             settle_reg;
   logic [9:0]              trigger_reg;
   logic [15:0]             gap_reg;
   logic signed [OFF_W-1:0] offset_reg;

   // sensor sequencer state
   phase_type               phase;
   logic [TIMER_W-1:0]      timer;
   logic [CNT_W-1:0]        attempt;
   logic [CNT_W-1:0]        good;
   logic [SUM_W-1:0]        echo_sum;
   logic [SPEED_W-1:0]      speed;

   tick_word_type           owed_words[$];
   int                      errors;
   int                      done_seen;
   int                      fail_seen;

   task automatic report_error(input string msg);
      errors++;
      if (errors <= 40)
         $display("%0t: %s", $time, msg);
   endtask

   function automatic void begin_settle();
      timer = '0;
      phase = (settle_reg == '0) ? PH_TRIG : PH_SETTLE;
   endfunction

   // closes one attempt; 1 when the whole measurement is over
   function automatic logic next_attempt();
      logic [CNT_W-1:0] limit;
      limit = (samples_reg == '0) ? CNT_W'(1) : samples_reg;
      if (limit > MAX_SAMPLES)
         limit = CNT_W'(MAX_SAMPLES);
      attempt = attempt + 1'b1;
      if (attempt >= limit) begin
         phase = PH_IDLE;
         timer = '0;
         return 1'b1;
      end
      begin_settle();
      return 1'b0;
   endfunction

   function automatic tick_word_type step_sensor(input logic start, input logic echo,
                                                 input logic [TEMP_W-1:0] temp);
      tick_word_type    w;
      logic             fin;
      logic [SUM_W-1:0] quotient;
      longint           dist_val;
      w = '0;
      fin = 1'b0;
      w.busy = (phase != PH_IDLE);
      case (phase)
         PH_IDLE: begin
            if (start) begin
               w.busy = 1'b1;
               speed = SPEED_BASE + SPEED_SLOPE * temp;
               attempt = '0;
               good = '0;
               echo_sum = '0;
               begin_settle();
            end
         end
         PH_SETTLE: begin
            timer = timer + 1'b1;
            if (timer >= settle_reg) begin
               phase = PH_TRIG;
               timer = '0;
            end
         end
         PH_TRIG: begin
            w.trigger = 1'b1;
            timer = timer + 1'b1;
            if (timer >= trigger_reg) begin
               phase = PH_WLOW;
               timer = '0;
            end
         end
         PH_WLOW: begin
            if (!echo) begin
               phase = PH_WHIGH;
               timer = '0;
            end else if (timer >= timeout_reg) begin
               fin = next_attempt();
            end else begin
               timer = timer + 1'b1;
            end
         end
         PH_WHIGH: begin
            if (echo) begin
               // first high tick already counts towards the width
               phase = PH_MEAS;
               timer = TIMER_W'(1);
            end else if (timer >= timeout_reg) begin
               fin = next_attempt();
            end else begin
               timer = timer + 1'b1;
            end
         end
         PH_MEAS: begin
            if (!echo) begin
               echo_sum = echo_sum + speed * timer;
               good = good + 1'b1;
               timer = '0;
               if (gap_reg == '0)
                  fin = next_attempt();
               else
                  phase = PH_GAP;
            end else if (timer >= timeout_reg) begin
               fin = next_attempt();
            end else begin
               timer = timer + 1'b1;
            end
         end
         PH_GAP: begin
            timer = timer + 1'b1;
            if (timer >= gap_reg)
               fin = next_attempt();
         end
         default: begin
            phase = PH_IDLE;
            timer = '0;
         end
      endcase
      if (fin) begin
         w.done = 1'b1;
         if (good == '0) begin
            w.failed = 1'b1;
         end else begin
            quotient = echo_sum / (good * DIV_SCALE);
            dist_val = longint'(quotient) - longint'(offset_reg);
            if (dist_val > DIST_HI)
               dist_val = DIST_HI;
            if (dist_val < DIST_LO)
               dist_val = DIST_LO;
            w.distance = dist_val[DIST_W-1:0];
         end
      end
      w.samples = good;
      return w;
   endfunction

   always @(posedge clock) begin
      tick_word_type want;
      if (reset) begin
         timeout_reg = TIMEOUT_RST;
         samples_reg = SAMPLES_RST;
         settle_reg = SETTLE_RST;
         trigger_reg = TRIGGER_RST;
         gap_reg = GAP_RST;
         offset_reg = '0;
         phase = PH_IDLE;
         timer = '0;
         attempt = '0;
         good = '0;
         echo_sum = '0;
         speed = '0;
         owed_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TIMEOUT: timeout_reg = csr_wdata[TIMER_W-1:0];
               CSR_SAMPLES: samples_reg = csr_wdata[CNT_W-1:0];
               CSR_SETTLE:  settle_reg  = csr_wdata[15:0];
               CSR_TRIGGER: trigger_reg = csr_wdata[9:0];
               CSR_GAP:     gap_reg     = csr_wdata[15:0];
               CSR_OFFSET:  offset_reg  = csr_wdata[OFF_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want = step_sensor(req_start_req, req_echo, req_temperature_tenths_c);
            if (want.done) begin
               done_seen++;
               if (want.failed)
                  fail_seen++;
            end
            owed_words.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_words.size() == 0) begin
               report_error("rsp word arrived with nothing outstanding");
            end else begin
               want = owed_words.pop_front();
               if (rsp_trigger !== want.trigger)
                  report_error($sformatf("trigger %b, wanted %b", rsp_trigger, want.trigger));
               if (rsp_busy_res !== want.busy)
                  report_error($sformatf("busy %b, wanted %b", rsp_busy_res, want.busy));
               if (rsp_done_res !== want.done)
                  report_error($sformatf("done %b, wanted %b", rsp_done_res, want.done));
               if (rsp_failed !== want.failed)
                  report_error($sformatf("failed %b, wanted %b", rsp_failed, want.failed));
               if (rsp_distance_hundredths_cm !== want.distance)
                  report_error($sformatf("distance %0d, wanted %0d",
                                         rsp_distance_hundredths_cm, want.distance));
               if (rsp_valid_samples !== want.samples)
                  report_error($sformatf("valid samples %0d, wanted %0d",
                                         rsp_valid_samples, want.samples));
            end
         end
      end
      error_count <= errors;
      words_owed <= owed_words.size();
      measurements <= done_seen;
      empty_measurements <= fail_seen;
   end

endmodule

>>> tb/ultrasonic_range_averager_test.sv
`timescale 1ns / 1ps

module ultrasonic_range_averager_test;
   import urav_pkg::*;

   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic signed [OFF_W-1:0] OFFSET_MIN = 15'sh4000;
   localparam logic signed [OFF_W-1:0] OFFSET_MAX = 15'sh3FFF;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_start_req = 1'b0;
   logic                     req_echo = 1'b0;
   logic [TEMP_W-1:0]        req_temperature_tenths_c = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_trigger;
   logic                     rsp_busy_res;
   logic                     rsp_done_res;
   logic                     rsp_failed;
   logic signed [DIST_W-1:0] rsp_distance_hundredths_cm;
   logic [CNT_W-1:0]         rsp_valid_samples;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_TIMEOUT;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   int error_count;
   int words_owed;
   int measurements;
   int empty_measurements;

   bit   pacing_on;
   bit   stall_on;
   int   burst_left;
   int   echo_left;
   int   echo_cap = 12;
   logic echo_level = 1'b0;
   int   ticks_sent;
   int   reg_writes;
   int   quiet;
   int   stall_mode;
   int   stall_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ultrasonic_range_averager DUT (.*);

   range_averager_check range_check (.*);

   // receiver: stall density is redrawn each time the stall counter wraps
   always @(posedge clock) begin
      if (stall_count == 100) begin
         stall_count <= 0;
         stall_mode <= $urandom_range(0, 3);
      end else begin
         stall_count <= stall_count + 1;
      end
      if (!stall_on || stall_mode == 0)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 7) < stall_mode * 2);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("ultrasonic_range_averager_test: done, errors");
         $finish;
      end
   end

   // one tick word; echo comes as runs of random length around the timeout
   task automatic send_tick(input logic start, input logic [TEMP_W-1:0] temp);
      int gap;
      if (pacing_on && burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      if (burst_left > 0)
         burst_left--;
      if (echo_left == 0) begin
         echo_level = ~echo_level;
         echo_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3 * echo_cap)
                                                  : $urandom_range(1, echo_cap);
      end
      echo_left--;
      req_valid <= 1'b1;
      req_start_req <= start;
      req_echo <= echo_level;
      req_temperature_tenths_c <= temp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   // start from idle and keep ticking until the measurement is over
   task automatic measure(input logic [TEMP_W-1:0] temp);
      int   seen;
      logic noise;
      repeat ($urandom_range(0, 3)) send_tick(1'b0, TEMP_W'($urandom_range(0, 511)));
      send_tick(1'b1, temp);
      seen = measurements;
      // done count lags by one word, so one word always follows the done tick
      do begin
         noise = ($urandom_range(0, 7) == 0);
         send_tick(noise, TEMP_W'($urandom_range(0, 511)));
      end while (measurements == seen);
      if (noise) begin
         seen = measurements;
         do send_tick(1'b0, TEMP_W'($urandom_range(0, 511)));
         while (measurements == seen);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      reg_writes++;
   endtask

   task automatic configure(input logic [TIMER_W-1:0] timeout, input logic [CNT_W-1:0] samples,
                            input logic [15:0] settle, input logic [9:0] trig,
                            input logic [15:0] gap, input logic signed [OFF_W-1:0] offset);
      drain_results();
      write_reg(CSR_TIMEOUT, CSR_DATA_W'(timeout));
      write_reg(CSR_SAMPLES, CSR_DATA_W'(samples));
      write_reg(CSR_SETTLE, CSR_DATA_W'(settle));
      write_reg(CSR_TRIGGER, CSR_DATA_W'(trig));
      write_reg(CSR_GAP, CSR_DATA_W'(gap));
      write_reg(CSR_OFFSET, CSR_DATA_W'(offset));
      csr_valid <= 1'b0;
      echo_cap = (timeout == '0) ? 2 : ((timeout > 11) ? 12 : int'(timeout) + 1);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: a few idle words flat out
      repeat (4) send_tick(1'b0, TEMP_W'($urandom_range(0, 511)));

      pacing_on = 1'b1;
      stall_on = 1'b1;
      configure(20'd6, 4'd3, 16'd2, 10'd1, 16'd2, 15'sd0);
      measure(TEMP_W'(0));
      measure(TEMP_W'(500));
      measure(TEMP_W'(511));
      // zero timeout, count, settle, trigger and gap; most negative offset
      configure(20'd0, 4'd0, 16'd0, 10'd0, 16'd0, OFFSET_MIN);
      measure(TEMP_W'($urandom_range(0, 511)));
      measure(TEMP_W'($urandom_range(0, 511)));
      // count above the cap, most positive offset
      configure(20'd1, 4'd15, 16'd1, 10'd1, 16'd1, OFFSET_MAX);
      measure(TEMP_W'(1));
      configure(20'd9, 4'd8, 16'd3, 10'd2, 16'd0, 15'sd10000);
      measure(TEMP_W'(256));
      configure(20'd4, 4'd1, 16'd0, 10'd3, 16'd5, -15'sd10000);
      measure(TEMP_W'(100));
      measure(TEMP_W'(400));

      while (ticks_sent < 400) begin
         pacing_on = ($urandom_range(0, 3) != 0);
         configure(TIMER_W'(($urandom_range(0, 4) == 0) ? $urandom_range(13, 60)
                                                         : $urandom_range(0, 12)),
                   CNT_W'($urandom_range(0, 15)),
                   16'($urandom_range(0, 4)),
                   10'($urandom_range(0, 5)),
                   16'($urandom_range(0, 4)),
                   OFF_W'($urandom));
         repeat ($urandom_range(1, 2)) measure(TEMP_W'($urandom_range(0, 511)));
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d tick words, %0d register writes, %0d measurements",
               ticks_sent, reg_writes, measurements);
      $display("%0d of those measurements had no good sample", empty_measurements);
      if (error_count == 0)
         $display("ultrasonic_range_averager_test: done, clean");
      else
         $display("ultrasonic_range_averager_test: done, errors");
      $finish;
   end

endmodule
